/* hdl/sea_pkg.sv */
// ----------------------------------------------------------------------------
// sea_pkg: shared types and constants of the series elastic actuator controller
// Payload structs, command and coefficient codes, fixed point limits.
// ----------------------------------------------------------------------------
package sea_pkg;

  localparam int NCOEF = 11;

  typedef enum logic [1:0] {
    CMD_STEP  = 2'd0,
    CMD_COEF  = 2'd1,
    CMD_SEED  = 2'd2,
    CMD_UNUSED = 2'd3
  } cmd_e;

  localparam logic [3:0] C_KP = 4'd0;
  localparam logic [3:0] C_KD = 4'd1;
  localparam logic [3:0] C_KI = 4'd2;
  localparam logic [3:0] C_KS = 4'd3;
  localparam logic [3:0] C_DAMP = 4'd4;
  localparam logic [3:0] C_INVI = 4'd5;
  localparam logic [3:0] C_FRIC = 4'd6;
  localparam logic [3:0] C_TLIM = 4'd7;
  localparam logic [3:0] C_UPPER = 4'd8;
  localparam logic [3:0] C_LOWER = 4'd9;
  localparam logic [3:0] C_LEN = 4'd10;

  localparam logic [0:0] REG_DIV = 1'd0;
  localparam logic [0:0] REG_PERIOD = 1'd1;

  typedef struct packed {
    logic [1:0]         command;
    logic [2:0]         joint;
    logic [3:0]         coef_select;
    logic signed [31:0] coef_value;
    logic signed [31:0] target_position;
    logic signed [31:0] link_position;
    logic signed [31:0] link_velocity;
    logic               end_of_tick;
  } in_item_t;

  typedef struct packed {
    logic [2:0]         out_joint;
    logic signed [31:0] link_effort;
    logic signed [31:0] motor_position;
    logic signed [31:0] motor_velocity;
    logic signed [31:0] drive_torque;
  } out_item_t;

  // Saturate a 66 bit signed value to 32 bits.
  function automatic logic signed [31:0] sat32(input logic signed [65:0] x);
    logic signed [65:0] hi;
    logic signed [65:0] lo;
    hi = 66'sd2147483647;
    lo = -66'sd2147483648;
    if (x > hi) return 32'sh7fffffff;
    else if (x < lo) return 32'sh80000000;
    else return x[31:0];
  endfunction

  // Clamp to plus or minus a limit; a negative limit acts as zero.
  function automatic logic signed [31:0] clamp_lim(input logic signed [65:0] t,
                                                   input logic signed [31:0] lim);
    logic signed [65:0] l;
    l = lim[31] ? 66'sd0 : 66'(lim);
    if (t >= l) return l[31:0];
    else if (t <= -l) return 32'(-l);
    else return t[31:0];
  endfunction

endpackage

/* hdl/sea_mul.sv */
// ----------------------------------------------------------------------------
// sea_mul: shared registered 33 by 33 signed multiplier
// One product per cycle, available in the cycle after the operands.
// ----------------------------------------------------------------------------
module sea_mul (
  input  logic               clk_i,
  input  logic signed [32:0] a_i,
  input  logic signed [32:0] b_i,
  output logic signed [65:0] p_o
);
  logic signed [65:0] p_q;

  // Register the product.
  always_ff @(posedge clk_i) begin
    p_q <= a_i * b_i;
  end
  assign p_o = p_q;
endmodule

/* hdl/sea_pid_with_motor_model.sv */
// ----------------------------------------------------------------------------
// sea_pid_with_motor_model: per joint PID controller with simulated motor
// Iterative datapath around one shared multiplier under a sequencer.
// ----------------------------------------------------------------------------
// Usage: items arrive on in_valid_i/in_ready_o as an in_item_t. A coefficient
// write or seed command passes through the read state and gives no result. A
// control step reads the joint's coefficients one per cycle from the
// coefficient memory, computes the error and integrator, then the remainder of
// the tick counter by the update divisor, one bit per cycle, and then runs
// twelve multiplications through the single shared multiplier. The block does
// not take the next item before the result of the current one has been
// registered in the output register and the sequencer has returned to idle.
// in_ready_o is low while an item is in work. A result is held on
// out_valid_o/out_item_o until the receiver takes it; a waiting result does
// not block the input, but a following control step holds in its last step
// until the output register is free, so a stalled receiver stalls the block.
// Configuration: cfg_we_i writes update_divisor (index 0) or tick_period
// (index 1) at once. Reset clears motor stores, integrators, tick counter
// and sets the registers to their defaults; the coefficient memory is
// undefined until written.
// ----------------------------------------------------------------------------
module sea_pid_with_motor_model
  import sea_pkg::*;
#(
  parameter int JOINTS = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  in_item_t    in_item_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output out_item_t   out_item_o,
  input  logic        cfg_we_i,
  input  logic [0:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i
);
  localparam int JW = (JOINTS > 1) ? $clog2(JOINTS) : 1;
  localparam int DEPTH = JOINTS * NCOEF;
  localparam int AW = $clog2(DEPTH + 1);

  typedef enum logic [2:0] {S_IDLE, S_READ, S_CALC, S_OUT} state_e;

  state_e state_q;
  in_item_t item_q;
  logic [15:0] div_q, tick_q;
  logic [31:0] period_q;
  logic signed [31:0] mpos_q [JOINTS];
  logic signed [31:0] mvel_q [JOINTS];
  logic signed [31:0] mtrq_q [JOINTS];
  logic signed [47:0] integ_q [JOINTS];
  logic signed [31:0] coef_mem [DEPTH];
  logic signed [31:0] rd_q;
  logic signed [31:0] c_q [NCOEF];
  logic [3:0] rcnt_q;
  logic [4:0] step_q;
  logic [15:0] mcnt_q;
  logic [15:0] mq_q;
  logic upd_q;
  logic signed [31:0] pos_q, vel_q, err_q, trq_q, eff_q, acc_q, dt2_q;
  logic signed [65:0] acc66_q;
  logic signed [47:0] ig_q;
  logic signed [32:0] ma, mb;
  logic signed [65:0] prod;
  out_item_t out_q;
  logic ov_q;
  logic done;
  logic [JW-1:0] j;
  logic jok;
  logic [AW-1:0] base;

  sea_mul u_mul (.clk_i(clk_i), .a_i(ma), .b_i(mb), .p_o(prod));

  assign j = item_q.joint[JW-1:0];
  assign jok = 32'(item_q.joint) < JOINTS;
  assign base = AW'(32'(j) * NCOEF);
  assign in_ready_o = (state_q == S_IDLE);
  assign out_valid_o = ov_q;
  assign out_item_o = out_q;
  // The last step completes only when the output register is free.
  assign done = (state_q == S_CALC) && (step_q == 5'd13) && (!ov_q || out_ready_i);

  // Coefficient memory: write on coefficient command, registered read.
  always_ff @(posedge clk_i) begin
    if (state_q == S_READ && item_q.command == CMD_COEF && jok
        && item_q.coef_select < 4'(NCOEF)) begin
      coef_mem[base + AW'(item_q.coef_select)] <= item_q.coef_value;
    end
    rd_q <= coef_mem[base + AW'(rcnt_q)];
  end

  // Multiplier operand selection per step; the product is used one step later.
  always_comb begin
    ma = '0;
    mb = '0;
    unique case (step_q)
      5'd1: begin ma = 33'($signed(ig_q[47:16])); mb = 33'(c_q[C_KI]); end
      5'd2: begin ma = {17'd0, ig_q[15:0]}; mb = 33'(c_q[C_KI]); end
      5'd3: begin ma = 33'(c_q[C_KP]); mb = 33'(err_q); end
      5'd4: begin ma = 33'(c_q[C_KD]); mb = 33'(vel_q); end
      5'd5: begin
        ma = 33'(c_q[C_KS]);
        mb = 33'(sat32(66'(pos_q) - 66'(item_q.link_position)));
      end
      5'd6: begin
        ma = 33'(c_q[C_DAMP]);
        mb = 33'(sat32(66'(vel_q) - 66'(item_q.link_velocity)));
      end
      5'd7: begin ma = 33'(c_q[C_FRIC]); mb = 33'(vel_q); end
      5'd8: begin ma = {1'b0, period_q}; mb = {1'b0, period_q}; end
      5'd9: begin ma = 33'(acc_q); mb = 33'(c_q[C_INVI]); end
      5'd10: begin ma = 33'(vel_q); mb = {1'b0, period_q}; end
      5'd11: begin ma = 33'(acc_q); mb = {1'b0, dt2_q}; end
      5'd12, 5'd13: begin ma = 33'(acc_q); mb = {1'b0, period_q}; end
      default: ;
    endcase
  end

  // Sequencer and datapath registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      ov_q <= 1'b0;
      div_q <= 16'd1;
      period_q <= 32'd4294967;
      tick_q <= '0;
      rcnt_q <= '0;
      step_q <= '0;
      for (int k = 0; k < JOINTS; k++) begin
        mpos_q[k] <= '0; mvel_q[k] <= '0; mtrq_q[k] <= '0; integ_q[k] <= '0;
      end
    end else begin
      if (cfg_we_i) begin
        if (cfg_index_i == REG_DIV) div_q <= cfg_data_i[15:0];
        else period_q <= cfg_data_i;
      end
      if (done) ov_q <= 1'b1;
      else if (out_ready_i) ov_q <= 1'b0;
      unique case (state_q)
        S_IDLE: begin
          if (in_valid_i && in_ready_o) begin
            item_q <= in_item_i;
            rcnt_q <= '0;
            state_q <= S_READ;
          end
        end
        S_READ: begin
          if (item_q.command != CMD_STEP || !jok) begin
            if (item_q.command == CMD_SEED && jok) begin
              mpos_q[j] <= item_q.link_position;
              mvel_q[j] <= item_q.link_velocity;
              tick_q <= '0;
            end else if (item_q.command == CMD_STEP && item_q.end_of_tick) begin
              tick_q <= tick_q + 16'd1;
            end
            state_q <= S_IDLE;
          end else begin
            if (rcnt_q != 4'd0) c_q[rcnt_q - 4'd1] <= rd_q;
            if (rcnt_q == 4'(NCOEF)) begin
              state_q <= S_CALC;
              step_q <= '0;
              mcnt_q <= '0;
              pos_q <= mpos_q[j];
              vel_q <= mvel_q[j];
            end
            rcnt_q <= rcnt_q + 4'd1;
          end
        end
        S_CALC: begin
          if (step_q != 5'd0 && step_q != 5'd20 && step_q != 5'd13) begin
            step_q <= step_q + 5'd1;
          end
          unique case (step_q)
            5'd0: begin
              // Limit target, compute error and integrator.
              logic signed [31:0] tg;
              logic signed [31:0] e;
              logic signed [48:0] s;
              tg = item_q.target_position;
              if (c_q[C_LEN] != 0) begin
                if (tg > c_q[C_UPPER]) tg = c_q[C_UPPER];
                else if (tg < c_q[C_LOWER]) tg = c_q[C_LOWER];
              end
              e = sat32(66'(tg) - 66'(pos_q));
              s = 49'(integ_q[j]) + 49'(e);
              if (s > 49'sh0_7fff_ffff_ffff) s = 49'sh0_7fff_ffff_ffff;
              else if (s < -49'sh0_8000_0000_0000) s = -49'sh0_8000_0000_0000;
              err_q <= e;
              ig_q <= s[47:0];
              integ_q[j] <= s[47:0];
              // Remainder of the tick counter by the divisor, one bit per step.
              mcnt_q <= '0;
              mq_q <= tick_q;
              rcnt_q <= '0;
              step_q <= 5'd20;
            end
            5'd20: begin
              logic [15:0] d;
              logic [16:0] r;
              d = (div_q == 16'd0) ? 16'd1 : div_q;
              r = {mcnt_q, mq_q[15]};
              if (r >= {1'b0, d}) r = r - {1'b0, d};
              mcnt_q <= r[15:0];
              mq_q <= {mq_q[14:0], 1'b0};
              rcnt_q <= rcnt_q + 4'd1;
              if (rcnt_q == 4'd15) begin
                upd_q <= (r[15:0] == 16'd0);
                step_q <= 5'd1;
              end
            end
            5'd2: acc66_q <= prod;
            5'd3: acc66_q <= acc66_q + (prod >>> 16);
            5'd4: acc66_q <= acc66_q + (prod >>> 16);
            5'd5: begin
              acc66_q <= upd_q ? acc66_q - (prod >>> 16) : 66'(mtrq_q[j]);
            end
            5'd6: begin
              trq_q <= clamp_lim(acc66_q, c_q[C_TLIM]);
              mtrq_q[j] <= clamp_lim(acc66_q, c_q[C_TLIM]);
              acc66_q <= prod >>> 16;
            end
            5'd7: begin
              eff_q <= clamp_lim(acc66_q + (prod >>> 16), c_q[C_TLIM]);
            end
            5'd8: begin
              acc_q <= sat32(66'(trq_q) - (prod >>> 16) - 66'(eff_q));
            end
            5'd9: dt2_q <= prod[63:32];
            5'd10: acc_q <= sat32(prod >>> 16);
            5'd11: acc66_q <= 66'(pos_q) + (prod >>> 32);
            5'd12: acc66_q <= acc66_q + (prod >>> 33);
            5'd13: begin
              logic signed [31:0] np, nv;
              np = sat32(acc66_q);
              nv = sat32(66'(vel_q) + (prod >>> 32));
              if (done) begin
                mpos_q[j] <= np;
                mvel_q[j] <= nv;
                if (item_q.end_of_tick) tick_q <= tick_q + 16'd1;
                out_q <= '{out_joint: item_q.joint, link_effort: eff_q,
                           motor_position: np, motor_velocity: nv,
                           drive_torque: trq_q};
                state_q <= S_IDLE;
              end
            end
            default: ;
          endcase
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end
endmodule

/* hdl/sea_checker.sv */
// ----------------------------------------------------------------------------
// sea_checker: port level checks of the actuator controller
// Watches handshakes at the top level ports.
// ----------------------------------------------------------------------------
module sea_checker
  import sea_pkg::*;
(
  input logic      clk_i,
  input logic      rst_ni,
  input logic      in_valid_i,
  input logic      in_ready_o,
  input logic      out_valid_o,
  input logic      out_ready_i,
  input out_item_t out_item_o
);
  // A held result keeps its payload.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_item_o))
    else $error("result changed while stalled");
  // A new result only comes while the block is busy.
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(!in_ready_o)) else $error("result while idle");
  // After an input transfer the block is busy next cycle.
  a_seq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o) else $error("ready after transfer");
  // A result never appears directly after a transfer.
  a_lat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && !out_valid_o |=> !out_valid_o)
    else $error("result too early");
endmodule

bind sea_pid_with_motor_model sea_checker u_chk (.*);

/* verif/tb_sea_pid_with_motor_model.sv */
// ----------------------------------------------------------------------------
// tb_sea_pid_with_motor_model: self-checking bench for the SEA joint controller
// Coefficient writes, motor seeds and control steps are offered on the input
// port under random idling on both sides. Every accepted control step is run
// through a fixed point model of the controller, and the result is checked
// field by field in transfer order. Several update divisor and tick period
// settings are exercised, the extremes among them.
// ----------------------------------------------------------------------------
module tb_sea_pid_with_motor_model;
  import sea_pkg::*;

  localparam int NJOINT = 8;
  localparam int IDLE_LIMIT = 5000;

  // Wide signed type so that no product or sum in the model can overflow.
  typedef logic signed [127:0] w_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  in_item_t    in_item_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  out_item_t   out_item_o;
  logic        cfg_we_i = 1'b0;
  logic [0:0]  cfg_index_i = REG_DIV;
  logic [31:0] cfg_data_i = '0;

  sea_pid_with_motor_model #(.JOINTS(NJOINT)) u_top (.*);

  initial forever #1 clk_i = ~clk_i;

  // Controller state as the bench tracks it.
  logic signed [31:0] coef_tab [NJOINT][NCOEF];
  logic signed [31:0] mot_pos [NJOINT];
  logic signed [31:0] mot_vel [NJOINT];
  logic signed [31:0] mot_trq [NJOINT];
  w_t                 integ_acc [NJOINT];
  logic [15:0]        tick_cnt;
  logic [15:0]        upd_div;
  logic [31:0]        period_q32;

  in_item_t  pending_items [$];
  out_item_t expected_results [$];
  int        err_cnt = 0;
  int        steps_taken = 0;
  int        idle_cycles = 0;
  bit        quiet = 1'b0;

  // Append an item to the pending queue.
  function automatic void queue_item(in_item_t it);
    pending_items.insert(pending_items.size(), it);
  endfunction

  function automatic w_t sat_to(w_t x, w_t lo, w_t hi);
    return (x < lo) ? lo : ((x > hi) ? hi : x);
  endfunction

  function automatic logic signed [31:0] sat_s32(w_t x);
    w_t r;
    r = sat_to(x, -w_t'(64'sd2147483648), w_t'(64'sd2147483647));
    return r[31:0];
  endfunction

  function automatic logic signed [31:0] clamp_trq(w_t x, logic signed [31:0] lim);
    w_t l;
    l = (lim < 0) ? w_t'(0) : w_t'(lim);
    if (x >= l) return l[31:0];
    if (x <= -l) return 32'(-l);
    return x[31:0];
  endfunction

  // Q16.16 product, floored.
  function automatic w_t qmul(logic signed [31:0] a, logic signed [31:0] b);
    return (w_t'(a) * w_t'(b)) >>> 16;
  endfunction

  // Apply one accepted item; returns 1 and the result for a control step.
  function automatic bit apply_item(in_item_t it, output out_item_t res);
    logic [2:0] j;
    logic signed [31:0] tgt, pos, vel, err, trq, eff, acc;
    w_t itg, hi, lo, t, num, dt, dt2;
    logic [15:0] div;
    res = '0;
    j = it.joint;
    if (it.command == CMD_COEF) begin
      if (it.coef_select < NCOEF) coef_tab[j][it.coef_select] = it.coef_value;
      return 1'b0;
    end
    if (it.command == CMD_SEED) begin
      mot_pos[j] = it.link_position;
      mot_vel[j] = it.link_velocity;
      tick_cnt = '0;
      return 1'b0;
    end
    if (it.command != CMD_STEP) return 1'b0;
    pos = mot_pos[j];
    vel = mot_vel[j];
    tgt = it.target_position;
    // Joint limits, upper bound first.
    if (coef_tab[j][C_LEN] != 0) begin
      if (tgt > coef_tab[j][C_UPPER]) tgt = coef_tab[j][C_UPPER];
      else if (tgt < coef_tab[j][C_LOWER]) tgt = coef_tab[j][C_LOWER];
    end
    err = sat_s32(w_t'(tgt) - w_t'(pos));
    itg = sat_to(integ_acc[j] + w_t'(err), -(w_t'(1) <<< 47), (w_t'(1) <<< 47) - 1);
    integ_acc[j] = itg;
    div = (upd_div == 0) ? 16'd1 : upd_div;
    // Torque recompute on divisor ticks, else hold the previous torque.
    if (tick_cnt % div == 0) begin
      hi = itg >>> 16;
      lo = itg - hi * 65536;
      t = w_t'(coef_tab[j][C_KI]) * hi + ((w_t'(coef_tab[j][C_KI]) * lo) >>> 16);
      t = t + qmul(coef_tab[j][C_KP], err) - qmul(coef_tab[j][C_KD], vel);
    end else begin
      t = w_t'(mot_trq[j]);
    end
    trq = clamp_trq(t, coef_tab[j][C_TLIM]);
    mot_trq[j] = trq;
    t = qmul(coef_tab[j][C_KS], sat_s32(w_t'(pos) - w_t'(it.link_position)))
      + qmul(coef_tab[j][C_DAMP], sat_s32(w_t'(vel) - w_t'(it.link_velocity)));
    eff = clamp_trq(t, coef_tab[j][C_TLIM]);
    num = w_t'(trq) - qmul(coef_tab[j][C_FRIC], vel) - w_t'(eff);
    acc = sat_s32(qmul(sat_s32(num), coef_tab[j][C_INVI]));
    // Motor integration over one period.
    dt = w_t'({96'd0, period_q32});
    dt2 = (dt * dt) >>> 32;
    mot_pos[j] = sat_s32(w_t'(pos) + ((w_t'(acc) * dt2) >>> 33)
                         + ((w_t'(vel) * dt) >>> 32));
    mot_vel[j] = sat_s32(w_t'(vel) + ((w_t'(acc) * dt) >>> 32));
    if (it.end_of_tick) tick_cnt = tick_cnt + 16'd1;
    res.out_joint = j;
    res.link_effort = eff;
    res.motor_position = mot_pos[j];
    res.motor_velocity = mot_vel[j];
    res.drive_torque = trq;
    return 1'b1;
  endfunction

  // Mostly moderate values, some extremes, some fully random.
  function automatic logic signed [31:0] pick_value();
    case ($urandom_range(0, 9))
      0: return 32'sh7fffffff;
      1: return 32'sh80000000;
      2: return 32'sd0;
      3, 4: return $urandom;
      default: return $signed($urandom_range(0, 32'h0010_0000)) - 32'sh0008_0000;
    endcase
  endfunction

  function automatic in_item_t make_item(cmd_e cmd, logic [2:0] j, logic [3:0] sel,
                                         logic signed [31:0] cval,
                                         logic signed [31:0] tgt,
                                         logic signed [31:0] lpos,
                                         logic signed [31:0] lvel, logic eot);
    in_item_t it;
    it.command = cmd;
    it.joint = j;
    it.coef_select = sel;
    it.coef_value = cval;
    it.target_position = tgt;
    it.link_position = lpos;
    it.link_velocity = lvel;
    it.end_of_tick = eot;
    return it;
  endfunction

  function automatic in_item_t random_step();
    return make_item(CMD_STEP, 3'($urandom_range(0, 7)), 4'($urandom), $urandom,
                     pick_value(), pick_value(), pick_value(), 1'($urandom));
  endfunction

  // Input driver: bursts of idling, otherwise the next pending item.
  int gap_left;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      gap_left <= 0;
    end else if (!in_valid_i || in_ready_o) begin
      if (gap_left > 0) begin
        gap_left <= gap_left - 1;
        in_valid_i <= 1'b0;
      end else if (!quiet && $urandom_range(0, 19) == 0) begin
        gap_left <= $urandom_range(0, 8);
        in_valid_i <= 1'b0;
      end else if (pending_items.size() > 0) begin
        in_valid_i <= 1'b1;
        in_item_i <= pending_items.pop_front();
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Receiver: random stalls, plus one long hold once traffic is flowing.
  int stall_left;
  int hold_left;
  bit hold_done;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b1;
      stall_left <= 0;
      hold_left <= 0;
      hold_done <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_ready_i <= 1'b0;
    end else if (!hold_done && steps_taken >= 150) begin
      hold_done <= 1'b1;
      hold_left <= 400;
      out_ready_i <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_ready_i <= 1'b0;
    end else if (!quiet && $urandom_range(0, 15) == 0) begin
      stall_left <= $urandom_range(0, 8);
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  // Monitor: predict on each input transfer, check each output transfer.
  always @(posedge clk_i) begin
    out_item_t res;
    out_item_t exp_r;
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) begin
        if (apply_item(in_item_i, res)) begin
          expected_results.insert(expected_results.size(), res);
          steps_taken <= steps_taken + 1;
        end
      end
      if (out_valid_o && out_ready_i) begin
        if (expected_results.size() == 0) begin
          $error("result with no expectation: joint %0d", out_item_o.out_joint);
          err_cnt++;
        end else begin
          exp_r = expected_results.pop_front();
          if (out_item_o.out_joint !== exp_r.out_joint) begin
            $error("out_joint expected %0d got %0d", exp_r.out_joint,
                   out_item_o.out_joint);
            err_cnt++;
          end
          if (out_item_o.link_effort !== exp_r.link_effort) begin
            $error("link_effort expected %0d got %0d", exp_r.link_effort,
                   out_item_o.link_effort);
            err_cnt++;
          end
          if (out_item_o.motor_position !== exp_r.motor_position) begin
            $error("motor_position expected %0d got %0d", exp_r.motor_position,
                   out_item_o.motor_position);
            err_cnt++;
          end
          if (out_item_o.motor_velocity !== exp_r.motor_velocity) begin
            $error("motor_velocity expected %0d got %0d", exp_r.motor_velocity,
                   out_item_o.motor_velocity);
            err_cnt++;
          end
          if (out_item_o.drive_torque !== exp_r.drive_torque) begin
            $error("drive_torque expected %0d got %0d", exp_r.drive_torque,
                   out_item_o.drive_torque);
            err_cnt++;
          end
        end
      end
      // Watchdog on cycles without any transfer.
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) || cfg_we_i) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
        $display("DONE: errors detected");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  task automatic write_reg(logic [0:0] idx, logic [31:0] data);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == REG_DIV) upd_div = data[15:0];
    else period_q32 = data;
  endtask

  // Wait until the block has drained, then let it settle.
  task automatic wait_drained();
    do @(negedge clk_i);
    while (pending_items.size() > 0 || in_valid_i || expected_results.size() > 0);
    repeat (40) @(negedge clk_i);
  endtask

  logic [15:0] div_set [5] = '{16'd1, 16'd0, 16'd65535, 16'd4, 16'd2};
  logic [31:0] per_set [5] = '{32'd4294967, 32'd65536, 32'hffff_ffff, 32'd1,
                               32'h4000_0000};

  initial begin
    in_item_t it;
    for (int j = 0; j < NJOINT; j++) begin
      mot_pos[j] = '0;
      mot_vel[j] = '0;
      mot_trq[j] = '0;
      integ_acc[j] = '0;
    end
    tick_cnt = '0;
    upd_div = 16'd1;
    period_q32 = 32'd4294967;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    for (int ph = 0; ph < 5; ph++) begin
      write_reg(REG_DIV, {16'd0, div_set[ph]});
      write_reg(REG_PERIOD, per_set[ph]);
      @(negedge clk_i);
      if (ph == 4) quiet = 1'b1;
      if (ph == 0) begin
        // Load every coefficient of every joint with a plausible setting.
        for (int j = 0; j < NJOINT; j++) begin
          for (int s = 0; s < NCOEF; s++) begin
            queue_item(make_item(CMD_COEF, 3'(j), 4'(s),
              (s == C_TLIM) ? 32'sh0100_0000 :
              (s == C_UPPER) ? 32'sh0004_0000 :
              (s == C_LOWER) ? -32'sh0004_0000 :
              (s == C_LEN) ? 32'sd1 : $signed($urandom_range(0, 32'h0003_0000)),
              0, 0, 0, 1'b0));
          end
        end
        // Target above and below the joint limits.
        queue_item(make_item(CMD_STEP, 3'd0, C_KP, 0, 32'sh7fffffff,
                             0, 0, 1'b1));
        queue_item(make_item(CMD_STEP, 3'd0, C_KP, 0, 32'sh80000000,
                             32'sh7fffffff, 32'sh80000000, 1'b1));
        // Limits disabled, extreme links, maximal integral gain.
        queue_item(make_item(CMD_COEF, 3'd1, C_LEN, 0, 0, 0, 0, 1'b0));
        queue_item(make_item(CMD_COEF, 3'd1, C_KI, 32'sh7fffffff,
                             0, 0, 0, 1'b0));
        for (int k = 0; k < 3; k++)
          queue_item(make_item(CMD_STEP, 3'd1, C_KP, 0, 32'sh7fffffff,
                               32'sh80000000, 32'sh7fffffff, 1'b0));
        // Negative torque limit acts as zero.
        queue_item(make_item(CMD_COEF, 3'd2, C_TLIM, 32'sh80000000,
                             0, 0, 0, 1'b0));
        queue_item(make_item(CMD_STEP, 3'd2, C_KP, 0, 32'sh0001_0000,
                             32'sh0002_0000, 32'sh0000_8000, 1'b1));
        // Huge torque limit and maximal inertia term.
        queue_item(make_item(CMD_COEF, 3'd3, C_TLIM, 32'sh7fffffff,
                             0, 0, 0, 1'b0));
        queue_item(make_item(CMD_COEF, 3'd3, C_INVI, 32'sh7fffffff,
                             0, 0, 0, 1'b0));
        queue_item(make_item(CMD_STEP, 3'd3, C_KP, 0, 32'sh7fffffff,
                             32'sh80000000, 32'sh80000000, 1'b0));
        // Ignored writes, unknown command, seed, then a step on the seeded joint.
        queue_item(make_item(CMD_COEF, 3'd4, 4'd11, 32'sh7fffffff,
                             0, 0, 0, 1'b0));
        queue_item(make_item(CMD_COEF, 3'd4, 4'd15, 32'sh80000000,
                             0, 0, 0, 1'b0));
        queue_item(make_item(CMD_UNUSED, 3'd7, 4'd15, 32'sh7fffffff,
                             32'sh7fffffff, 32'sh7fffffff,
                             32'sh7fffffff, 1'b1));
        queue_item(make_item(CMD_SEED, 3'd7, C_KP, 0, 0, 32'sh7fffffff,
                             32'sh80000000, 1'b1));
        queue_item(make_item(CMD_STEP, 3'd7, C_KP, 0, 0, 0, 0, 1'b1));
      end
      // Random traffic, mostly control steps with occasional retuning.
      for (int n = 0; n < 360; n++) begin
        case ($urandom_range(0, 19))
          0, 1: it = make_item(CMD_COEF, 3'($urandom_range(0, 7)),
                               4'($urandom_range(0, 15)), pick_value(),
                               $urandom, $urandom, $urandom, 1'($urandom));
          2: it = make_item(CMD_SEED, 3'($urandom_range(0, 7)), 4'($urandom),
                            $urandom, $urandom, pick_value(), pick_value(),
                            1'($urandom));
          3: it = make_item(CMD_UNUSED, 3'($urandom), 4'($urandom), $urandom,
                            $urandom, $urandom, $urandom, 1'($urandom));
          default: it = random_step();
        endcase
        queue_item(it);
      end
      wait_drained();
    end

    if (err_cnt == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
